/* design/complex_arith_unit_core_defines.svh */
// Assertion macros for the complex arithmetic unit.
// Included by the modules that carry concurrent assertions; no other dependencies.
`ifndef COMPLEX_ARITH_UNIT_CORE_DEFINES_SVH
`define COMPLEX_ARITH_UNIT_CORE_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked on every rising clock edge outside reset.
`define CAU_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("complex arith unit assertion failed");

// Next-cycle implication.
`define CAU_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("complex arith unit assertion failed");

`else

`define CAU_ASSERT_NOW(lbl, clk, rst, ante, cons)
`define CAU_ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

/* design/cau_pkg.sv */
// Shared types, constants and helper functions for the complex arithmetic unit.
// No dependencies.
`timescale 1ns / 1ps

package cau_pkg;

   // Field width and default fraction bits of the Q format.
   localparam int CAU_WIDTH     = 16;
   localparam int CAU_FRAC_BITS = 8;
   localparam int CAU_FRAC_MAX  = 15;

   // Product and magnitude widths.
   localparam int CAU_PW    = 2 * CAU_WIDTH;
   localparam int CAU_SW    = 2 * CAU_WIDTH + 1;
   localparam int CAU_MW    = 2 * CAU_WIDTH;
   // Divider remainder width: holds the shifted numerator and the shifted divisor.
   localparam int CAU_REM_W = 2 * CAU_WIDTH + CAU_FRAC_MAX + 1;

   typedef enum logic [1:0] {
      CAU_CMD_ADD = 2'd0,
      CAU_CMD_SUB = 2'd1,
      CAU_CMD_MUL = 2'd2,
      CAU_CMD_DIV = 2'd3
   } cau_cmd_type;

   typedef struct packed {
      cau_cmd_type                   command;
      logic signed [CAU_WIDTH-1:0]   a_real;
      logic signed [CAU_WIDTH-1:0]   a_imag;
      logic signed [CAU_WIDTH-1:0]   b_real;
      logic signed [CAU_WIDTH-1:0]   b_imag;
   } cau_req_type;

   typedef struct packed {
      logic signed [CAU_WIDTH-1:0]   res_real;
      logic signed [CAU_WIDTH-1:0]   res_imag;
      logic                          div_zero;
      logic                          saturated;
   } cau_rsp_type;

   // One result part of the divider: remainder, quotient so far, sign, overflow.
   typedef struct packed {
      logic [CAU_REM_W-1:0]  rem;
      logic [CAU_WIDTH-1:0]  quo;
      logic                  neg;
      logic                  ovf;
   } cau_lane_type;

   // Item as it travels through the divider cells.
   typedef struct packed {
      cau_lane_type          re;
      cau_lane_type          im;
      logic [CAU_MW-1:0]     den;
      logic                  is_div;
      cau_rsp_type           fixed;
   } cau_div_type;

   typedef struct packed {
      logic                  sat;
      logic [CAU_WIDTH-1:0]  val;
   } cau_clip_type;

   // Saturate a sign-magnitude value to a CAU_WIDTH-bit two's complement part.
   function automatic cau_clip_type cau_clip(input logic neg, input logic [CAU_MW-1:0] mag,
                                             input logic big);
      cau_clip_type r;
      logic [CAU_MW-1:0] lim_neg;
      logic [CAU_MW-1:0] lim_pos;
      lim_neg = CAU_MW'(1) << (CAU_WIDTH - 1);
      lim_pos = lim_neg - CAU_MW'(1);
      if (neg) begin
         if (big || (mag > lim_neg)) begin
            r.sat = 1'b1;
            r.val = lim_neg[CAU_WIDTH-1:0];
         end else begin
            r.sat = 1'b0;
            r.val = -mag[CAU_WIDTH-1:0];
         end
      end else begin
         if (big || (mag > lim_pos)) begin
            r.sat = 1'b1;
            r.val = lim_pos[CAU_WIDTH-1:0];
         end else begin
            r.sat = 1'b0;
            r.val = mag[CAU_WIDTH-1:0];
         end
      end
      return r;
   endfunction

endpackage

/* design/cau_front.sv */
// Front end of the complex arithmetic unit: products, sums, add/sub/multiply results,
// and divider setup. Depends on cau_pkg.
`timescale 1ns / 1ps

module cau_front #(
   parameter int FRAC_BITS = cau_pkg::CAU_FRAC_BITS
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  cau_pkg::cau_req_type in_data,
   output logic                 out_valid,
   input  logic                 out_ready,
   output cau_pkg::cau_div_type out_data
);

   localparam int W  = cau_pkg::CAU_WIDTH;
   localparam int PW = cau_pkg::CAU_PW;
   localparam int SW = cau_pkg::CAU_SW;
   localparam int MW = cau_pkg::CAU_MW;
   localparam int RW = cau_pkg::CAU_REM_W;

   typedef struct packed {
      cau_pkg::cau_cmd_type    cmd;
      logic signed [PW-1:0]    p_rr;
      logic signed [PW-1:0]    p_ii;
      logic signed [PW-1:0]    p_ir;
      logic signed [PW-1:0]    p_ri;
      logic signed [PW-1:0]    d_rr;
      logic signed [PW-1:0]    d_ii;
      logic signed [W:0]       s_re;
      logic signed [W:0]       s_im;
   } st1_type;

   typedef struct packed {
      cau_pkg::cau_cmd_type    cmd;
      logic signed [SW-1:0]    n_re;
      logic signed [SW-1:0]    n_im;
      logic [MW-1:0]           den;
      cau_pkg::cau_clip_type   c_re;
      cau_pkg::cau_clip_type   c_im;
   } st2_type;

   logic                 v1_ff, v2_ff, v3_ff;
   logic                 rdy1, rdy2, rdy3;
   st1_type              s1_ff, s1_in;
   st2_type              s2_ff, s2_in;
   cau_pkg::cau_div_type s3_ff, s3_in;

   // Each stage takes an item when it is empty or its item moves on.
   assign rdy3     = !v3_ff || out_ready;
   assign rdy2     = !v2_ff || rdy3;
   assign rdy1     = !v1_ff || rdy2;
   assign in_ready = rdy1;

   // Stage one: the six partial products and the add/subtract sums.
   always_comb begin
      s1_in.cmd  = in_data.command;
      s1_in.p_rr = PW'(in_data.a_real) * PW'(in_data.b_real);
      s1_in.p_ii = PW'(in_data.a_imag) * PW'(in_data.b_imag);
      s1_in.p_ir = PW'(in_data.a_imag) * PW'(in_data.b_real);
      s1_in.p_ri = PW'(in_data.a_real) * PW'(in_data.b_imag);
      s1_in.d_rr = PW'(in_data.b_real) * PW'(in_data.b_real);
      s1_in.d_ii = PW'(in_data.b_imag) * PW'(in_data.b_imag);
      if (in_data.command == cau_pkg::CAU_CMD_SUB) begin
         s1_in.s_re = (W+1)'(in_data.a_real) - (W+1)'(in_data.b_real);
         s1_in.s_im = (W+1)'(in_data.a_imag) - (W+1)'(in_data.b_imag);
      end else begin
         s1_in.s_re = (W+1)'(in_data.a_real) + (W+1)'(in_data.b_real);
         s1_in.s_im = (W+1)'(in_data.a_imag) + (W+1)'(in_data.b_imag);
      end
   end

   // Stage two: product sums, divisor magnitude and add/subtract saturation.
   always_comb begin
      logic [W:0] m_re;
      logic [W:0] m_im;
      m_re = s1_ff.s_re[W] ? (W+1)'(-s1_ff.s_re) : (W+1)'(s1_ff.s_re);
      m_im = s1_ff.s_im[W] ? (W+1)'(-s1_ff.s_im) : (W+1)'(s1_ff.s_im);
      s2_in.cmd = s1_ff.cmd;
      if (s1_ff.cmd == cau_pkg::CAU_CMD_DIV) begin
         s2_in.n_re = SW'(s1_ff.p_rr) + SW'(s1_ff.p_ii);
         s2_in.n_im = SW'(s1_ff.p_ir) - SW'(s1_ff.p_ri);
      end else begin
         s2_in.n_re = SW'(s1_ff.p_rr) - SW'(s1_ff.p_ii);
         s2_in.n_im = SW'(s1_ff.p_ir) + SW'(s1_ff.p_ri);
      end
      s2_in.den  = MW'($unsigned(s1_ff.d_rr)) + MW'($unsigned(s1_ff.d_ii));
      s2_in.c_re = cau_pkg::cau_clip(s1_ff.s_re[W], MW'(m_re), 1'b0);
      s2_in.c_im = cau_pkg::cau_clip(s1_ff.s_im[W], MW'(m_im), 1'b0);
   end

   // Stage three: multiply scaling and saturation, divider operands and overflow check.
   always_comb begin
      logic [MW-1:0]         a_re;
      logic [MW-1:0]         a_im;
      logic [MW-1:0]         t_re;
      logic [MW-1:0]         t_im;
      logic [RW-1:0]         lim;
      cau_pkg::cau_clip_type k_re;
      cau_pkg::cau_clip_type k_im;
      a_re = s2_ff.n_re[SW-1] ? MW'(-s2_ff.n_re) : MW'(s2_ff.n_re);
      a_im = s2_ff.n_im[SW-1] ? MW'(-s2_ff.n_im) : MW'(s2_ff.n_im);
      t_re = a_re >> FRAC_BITS;
      t_im = a_im >> FRAC_BITS;
      k_re = cau_pkg::cau_clip(s2_ff.n_re[SW-1] && (t_re != '0), t_re, 1'b0);
      k_im = cau_pkg::cau_clip(s2_ff.n_im[SW-1] && (t_im != '0), t_im, 1'b0);
      lim  = RW'(s2_ff.den) << W;

      s3_in.re.rem = RW'(a_re) << FRAC_BITS;
      s3_in.re.quo = '0;
      s3_in.re.neg = s2_ff.n_re[SW-1];
      s3_in.re.ovf = (RW'(a_re) << FRAC_BITS) >= lim;
      s3_in.im.rem = RW'(a_im) << FRAC_BITS;
      s3_in.im.quo = '0;
      s3_in.im.neg = s2_ff.n_im[SW-1];
      s3_in.im.ovf = (RW'(a_im) << FRAC_BITS) >= lim;
      s3_in.den    = s2_ff.den;
      s3_in.is_div = (s2_ff.cmd == cau_pkg::CAU_CMD_DIV) && (s2_ff.den != '0);

      unique case (s2_ff.cmd)
         cau_pkg::CAU_CMD_ADD, cau_pkg::CAU_CMD_SUB: begin
            s3_in.fixed.res_real  = s2_ff.c_re.val;
            s3_in.fixed.res_imag  = s2_ff.c_im.val;
            s3_in.fixed.div_zero  = 1'b0;
            s3_in.fixed.saturated = s2_ff.c_re.sat || s2_ff.c_im.sat;
         end
         cau_pkg::CAU_CMD_MUL: begin
            s3_in.fixed.res_real  = k_re.val;
            s3_in.fixed.res_imag  = k_im.val;
            s3_in.fixed.div_zero  = 1'b0;
            s3_in.fixed.saturated = k_re.sat || k_im.sat;
         end
         default: begin
            // Division by a zero divisor; ignored for a nonzero one.
            s3_in.fixed.res_real  = '0;
            s3_in.fixed.res_imag  = '0;
            s3_in.fixed.div_zero  = 1'b1;
            s3_in.fixed.saturated = 1'b0;
         end
      endcase
   end

   // Stage valid bits.
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         if (rdy1) v1_ff <= in_valid;
         if (rdy2) v2_ff <= v1_ff;
         if (rdy3) v3_ff <= v2_ff;
      end
   end

   // Stage payloads.
   always_ff @(posedge clock) begin
      if (rdy1 && in_valid) s1_ff <= s1_in;
      if (rdy2 && v1_ff) s2_ff <= s2_in;
      if (rdy3 && v2_ff) s3_ff <= s3_in;
   end

   assign out_valid = v3_ff;
   assign out_data  = s3_ff;

endmodule

/* design/cau_div_cell.sv */
// One cell of the divider chain: a restoring step for both result parts.
// Depends on cau_pkg.
`timescale 1ns / 1ps

module cau_div_cell #(
   parameter int SHIFT = 0
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  cau_pkg::cau_div_type in_data,
   output logic                 out_valid,
   input  logic                 out_ready,
   output cau_pkg::cau_div_type out_data
);

   localparam int W  = cau_pkg::CAU_WIDTH;
   localparam int RW = cau_pkg::CAU_REM_W;

   logic                 valid_ff;
   cau_pkg::cau_div_type data_ff, data_in;

   assign in_ready = !valid_ff || out_ready;

   // Compare each remainder with the divisor at this cell's bit weight.
   always_comb begin
      logic [RW-1:0] dsh;
      dsh     = RW'(in_data.den) << SHIFT;
      data_in = in_data;
      if (in_data.re.rem >= dsh) begin
         data_in.re.rem = in_data.re.rem - dsh;
         data_in.re.quo = {in_data.re.quo[W-2:0], 1'b1};
      end else begin
         data_in.re.quo = {in_data.re.quo[W-2:0], 1'b0};
      end
      if (in_data.im.rem >= dsh) begin
         data_in.im.rem = in_data.im.rem - dsh;
         data_in.im.quo = {in_data.im.quo[W-2:0], 1'b1};
      end else begin
         data_in.im.quo = {in_data.im.quo[W-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) data_ff <= data_in;
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

/* design/complex_arith_unit_core.sv */
// Complex arithmetic unit on signed fixed-point parts: add, subtract, multiply, divide.
// Each item passes through three front-end stages, one divider cell per quotient bit and
// the output register. Every command takes the same path, so results keep their order.
// Throughput is one item per cycle when the result side keeps up; the ready signal
// only drops when every stage holds an item and the output is stalled.
// Depends on cau_pkg, cau_front, cau_div_cell and complex_arith_unit_core_defines.svh.
`timescale 1ns / 1ps
`include "complex_arith_unit_core_defines.svh"

module complex_arith_unit_core #(
   parameter int FRAC_BITS = cau_pkg::CAU_FRAC_BITS
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  cau_pkg::cau_req_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output cau_pkg::cau_rsp_type rsp_data
);

   localparam int W  = cau_pkg::CAU_WIDTH;
   localparam int MW = cau_pkg::CAU_MW;

   logic                 chain_valid [W+1];
   logic                 chain_ready [W+1];
   cau_pkg::cau_div_type chain_data  [W+1];

   logic                 rsp_valid_ff;
   cau_pkg::cau_rsp_type rsp_data_ff, rsp_data_in;
   logic                 last_ready;

   cau_front #(
      .FRAC_BITS (FRAC_BITS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_data   (req_data),
      .out_valid (chain_valid[0]),
      .out_ready (chain_ready[0]),
      .out_data  (chain_data[0])
   );

   // Divider chain, most significant quotient bit first.
   for (genvar k = 0; k < W; k++) begin : g_cell
      cau_div_cell #(
         .SHIFT (W - 1 - k)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (chain_valid[k]),
         .in_ready  (chain_ready[k]),
         .in_data   (chain_data[k]),
         .out_valid (chain_valid[k+1]),
         .out_ready (chain_ready[k+1]),
         .out_data  (chain_data[k+1])
      );
   end

   assign last_ready     = !rsp_valid_ff || rsp_ready;
   assign chain_ready[W] = last_ready;

   // Final sign and saturation of the quotients, or the result computed up front.
   always_comb begin
      cau_pkg::cau_div_type  d;
      cau_pkg::cau_clip_type q_re;
      cau_pkg::cau_clip_type q_im;
      d    = chain_data[W];
      q_re = cau_pkg::cau_clip(d.re.neg && ((d.re.quo != '0) || d.re.ovf), MW'(d.re.quo),
                               d.re.ovf);
      q_im = cau_pkg::cau_clip(d.im.neg && ((d.im.quo != '0) || d.im.ovf), MW'(d.im.quo),
                               d.im.ovf);
      if (d.is_div) begin
         rsp_data_in.res_real  = q_re.val;
         rsp_data_in.res_imag  = q_im.val;
         rsp_data_in.div_zero  = 1'b0;
         rsp_data_in.saturated = q_re.sat || q_im.sat;
      end else begin
         rsp_data_in = d.fixed;
      end
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (last_ready) begin
         rsp_valid_ff <= chain_valid[W];
      end
   end

   always_ff @(posedge clock) begin
      if (last_ready && chain_valid[W]) rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `CAU_ASSERT_NOW(a_dz_zero, clock, reset, rsp_valid_ff && rsp_data_ff.div_zero,
      !rsp_data_ff.saturated && (rsp_data_ff.res_real == '0) && (rsp_data_ff.res_imag == '0))
   `CAU_ASSERT_NOW(a_sat_limit, clock, reset, rsp_valid_ff && rsp_data_ff.saturated,
      (rsp_data_ff.res_real == {1'b0, {(W-1){1'b1}}}) ||
      (rsp_data_ff.res_real == {1'b1, {(W-1){1'b0}}}) ||
      (rsp_data_ff.res_imag == {1'b0, {(W-1){1'b1}}}) ||
      (rsp_data_ff.res_imag == {1'b1, {(W-1){1'b0}}}))
   `CAU_ASSERT_NEXT(a_out_load, clock, reset, chain_valid[W] && last_ready, rsp_valid_ff)

endmodule
